FILE: hdl/rthp_pkg.sv
// ----------------------------------------------------------------------------
// rthp_pkg: shared types and constants for the RGB to HSL pixel converter
// Holds the word that travels down the division chain and the field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package rthp_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumCells = 8;
  localparam int unsigned PixW     = 3 * ChanW;

  // Work word of one pixel in flight. Each division keeps a running
  // remainder, a divisor aligned to the current quotient bit and the
  // quotient bits found so far.
  typedef struct packed {
    logic [ChanW-1:0] lig;
    logic [15:0]      s_rem;
    logic [15:0]      s_dsh;
    logic [ChanW-1:0] s_quo;
    logic [18:0]      h_rem;
    logic [17:0]      h_dsh;
    logic [ChanW-1:0] h_quo;
  } rthp_work_t;

endpackage
`default_nettype wire

FILE: hdl/rgb_to_hsl_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel: streaming RGB to HSL pixel converter
// Converts one 8-bit RGB pixel per clock, unless the output stalls, into 8-bit hue, saturation, lightness.
// ----------------------------------------------------------------------------
//
//  Channel     Direction  Payload (tdata, lowest bit first)
//  s_axis_*    in         red[7:0], green[15:8], blue[23:16]
//  m_axis_*    out        hue[7:0], saturation[15:8], lightness[23:16]
//
// A request is taken every clock while the pipeline is not stalled. Each
// request passes one front-end register, then eight division cells that
// each settle one quotient bit of the saturation and the hue divisions; the
// result is shown by the last cell. The number of cells is set by the
// eight-bit quotient of the division chain. The whole pipeline, bubbles
// included, holds while a result waits unaccepted at the output.
// Reset clears only the valid bits.
`default_nettype none
module rgb_to_hsl_pixel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // red[7:0], green[15:8], blue[23:16]
  input  logic [rthp_pkg::PixW-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // hue[7:0], saturation[15:8], lightness[23:16]
  output logic [rthp_pkg::PixW-1:0] m_axis_tdata
);
  import rthp_pkg::*;

  rthp_work_t prep_w, prep_q;
  logic       prep_vq;
  logic       en;
  rthp_work_t chain_w [NumCells+1];
  logic       chain_v [NumCells+1];

  // Only the output stage can hold the chain back; bubbles do not.
  assign en            = !chain_v[NumCells] || m_axis_tready;
  assign s_axis_tready = en;

  rthp_prep u_prep (
    .red_i   (s_axis_tdata[ChanW-1:0]),
    .green_i (s_axis_tdata[2*ChanW-1:ChanW]),
    .blue_i  (s_axis_tdata[3*ChanW-1:2*ChanW]),
    .work_o  (prep_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vq <= 1'b0;
    end else if (en) begin
      prep_vq <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_w;
    end
  end

  assign chain_w[0] = prep_q;
  assign chain_v[0] = prep_vq;

  // Each cell resolves the next lower quotient bit of both divisions.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rthp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[k]),
      .work_i  (chain_w[k]),
      .valid_o (chain_v[k+1]),
      .work_o  (chain_w[k+1])
    );
  end

  assign m_axis_tvalid = chain_v[NumCells];
  assign m_axis_tdata  = {chain_w[NumCells].lig, chain_w[NumCells].s_quo,
                          chain_w[NumCells].h_quo};

endmodule
`default_nettype wire

FILE: hdl/rthp_prep.sv
// ----------------------------------------------------------------------------
// rthp_prep: front end of the converter
// Finds max, min and spread, the lightness, and both division operands.
// ----------------------------------------------------------------------------
`default_nettype none
module rthp_prep (
  input  logic [rthp_pkg::ChanW-1:0] red_i,
  input  logic [rthp_pkg::ChanW-1:0] green_i,
  input  logic [rthp_pkg::ChanW-1:0] blue_i,
  output rthp_pkg::rthp_work_t       work_o
);
  import rthp_pkg::*;

  logic [7:0]         mx, mn, d;
  logic [8:0]         sum, sden;
  logic [9:0]         inv_sum;
  logic               gray;
  logic signed [11:0] hraw, hadj;
  logic [10:0]        d6, hn, hden;
  logic [15:0]        gray_l;
  logic [16:0]        col_l;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i  > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i  < mn) mn = blue_i;
    gray    = (mx == mn);
    d       = mx - mn;
    sum     = {1'b0, mx} + {1'b0, mn};
    inv_sum = 10'd512 - {1'b0, sum};
    d6      = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};

    if (red_i == mx) begin
      hraw = $signed({4'b0, green_i}) - $signed({4'b0, blue_i});
    end else if (green_i == mx) begin
      hraw = $signed({3'b0, d, 1'b0}) + $signed({4'b0, blue_i})
           - $signed({4'b0, red_i});
    end else begin
      hraw = $signed({2'b0, d, 2'b0}) + $signed({4'b0, red_i})
           - $signed({4'b0, green_i});
    end
    // Negative hue wraps by one full turn.
    hadj = hraw[11] ? hraw + $signed({1'b0, d6}) : hraw;
    hn   = hadj[10:0];

    sden = sum[8] ? inv_sum[8:0] : sum;
    if (gray) begin
      sden = 9'd1;
      hden = 11'd1;
    end else begin
      hden = d6;
    end

    gray_l = {mx, 8'b0} - {8'b0, mx};
    col_l  = {sum, 8'b0} - {8'b0, sum};

    work_o.lig   = gray ? gray_l[15:8] : col_l[16:9];
    work_o.s_rem = {d, 8'b0} - {8'b0, d};
    work_o.s_dsh = {sden[8:0], 7'b0};
    work_o.s_quo = '0;
    work_o.h_rem = {hn, 8'b0} - {8'b0, hn};
    work_o.h_dsh = {hden, 7'b0};
    work_o.h_quo = '0;
  end

endmodule
`default_nettype wire

FILE: hdl/rthp_div_cell.sv
// ----------------------------------------------------------------------------
// rthp_div_cell: one restoring division step for saturation and hue
// Resolves one quotient bit of each division and hands the word onward.
// ----------------------------------------------------------------------------
`default_nettype none
module rthp_div_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rthp_pkg::rthp_work_t work_i,
  output logic                 valid_o,
  output rthp_pkg::rthp_work_t work_o
);
  import rthp_pkg::*;

  rthp_work_t work_d, work_q;
  logic       valid_q, s_bit, h_bit;

  always_comb begin
    s_bit        = (work_i.s_rem >= work_i.s_dsh);
    h_bit        = (work_i.h_rem >= {1'b0, work_i.h_dsh});
    work_d       = work_i;
    work_d.s_rem = s_bit ? work_i.s_rem - work_i.s_dsh : work_i.s_rem;
    work_d.h_rem = h_bit ? work_i.h_rem - {1'b0, work_i.h_dsh} : work_i.h_rem;
    work_d.s_dsh = work_i.s_dsh >> 1;
    work_d.h_dsh = work_i.h_dsh >> 1;
    work_d.s_quo = {work_i.s_quo[ChanW-2:0], s_bit};
    work_d.h_quo = {work_i.h_quo[ChanW-2:0], h_bit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule
`default_nettype wire

FILE: hdl/rthp_checker.sv
// ----------------------------------------------------------------------------
// rthp_checker: port-level checks for the RGB to HSL converter
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rthp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [rthp_pkg::PixW-1:0] s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [rthp_pkg::PixW-1:0] m_axis_tdata
);
  import rthp_pkg::*;

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // With no result pending the input side never stalls.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Hue lies below one full turn.
  a_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[ChanW-1:0] != 8'hFF)
    else $error("hue reached a full turn");

  // No result shows right after reset.
  a_fresh: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result right after reset");

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ (^s_axis_tdata);

endmodule

bind rgb_to_hsl_pixel rthp_checker u_rthp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: test/rgb_to_hsl_pixel_test.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_test: self-checking bench for the RGB to HSL converter
// Streams pixels with random idling on both sides and compares every result
// against an integer HSL predictor, field by field, in request order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsl_pixel_test;

  localparam int unsigned PixW = rthp_pkg::PixW;
  localparam int          DrainCycles = 40;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [PixW-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [PixW-1:0] m_axis_tdata;

  // Pixels waiting to be sent, and the HSL words expected back, oldest first.
  logic [PixW-1:0] pixel_queue[$];
  logic [PixW-1:0] hsl_expected[$];
  int              mismatches = 0;
  int              send_gap = 0;
  int              take_gap = 0;
  bit              calm = 1'b0;   // no idling in the closing stretch

  always #2 clk_i = ~clk_i;

  rgb_to_hsl_pixel DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Integer HSL of one pixel, packed as hue, saturation, lightness from bit 0.
  function automatic logic [PixW-1:0] hsl_of(logic [PixW-1:0] pix);
    int r, g, b, mx, mn, d, sum, num;
    logic [7:0] hue, sat, lig;
    r = pix[7:0];
    g = pix[15:8];
    b = pix[23:16];
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    hue = '0;
    sat = '0;
    if (mx == mn) begin
      lig = 8'((255 * mx) / 256);
    end else begin
      sum = mx + mn;
      d = mx - mn;
      lig = 8'((255 * sum) / 512);
      if (sum < 256) sat = 8'((255 * d) / sum);
      else sat = 8'((255 * d) / (512 - sum));
      // Red wins ties over green, green over blue.
      if (r == mx) num = g - b;
      else if (g == mx) num = 2 * d + b - r;
      else num = 4 * d + r - g;
      if (num < 0) num += 6 * d;
      hue = 8'((255 * num) / (6 * d));
    end
    return {lig, sat, hue};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Driver: presents the next pixel and holds it until it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 10);
          s_axis_tvalid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          s_axis_tdata <= pixel_queue[0];
          hsl_expected.push_back(hsl_of(pixel_queue[0]));
          void'(pixel_queue.pop_front());
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and stalls the output at random.
  always @(posedge clk_i) begin
    logic [PixW-1:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hsl_expected.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 0);
        end else begin
          want = hsl_expected.pop_front();
          if (m_axis_tdata[7:0] !== want[7:0])
            report_mismatch("hue", m_axis_tdata[7:0], want[7:0]);
          if (m_axis_tdata[15:8] !== want[15:8])
            report_mismatch("saturation", m_axis_tdata[15:8], want[15:8]);
          if (m_axis_tdata[23:16] !== want[23:16])
            report_mismatch("lightness", m_axis_tdata[23:16], want[23:16]);
        end
      end
      if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        take_gap <= $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 3));
      3: return 8'($urandom_range(252, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0] c0, c1;
    // Directed: black, white, grays, pure and secondary colors, sector ties,
    // negative hue in the red sector, and both saturation branches.
    pixel_queue = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'h7F7F7F,
      24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00,
      24'hFF00FF, 24'h0100FF, 24'hFF0001, 24'h7F0080, 24'h807F00,
      24'h00FEFF, 24'hFEFFFF, 24'h000100, 24'hFFFEFE, 24'h102030,
      24'h804020, 24'h7F7F80, 24'h55AA55, 24'h0F00F0
    };
    repeat (850) begin
      c0 = pick_chan();
      c1 = pick_chan();
      case ($urandom_range(0, 4))
        0: pixel_queue.push_back({c0, c0, c0});
        1: pixel_queue.push_back({c1, c0, c0});
        2: pixel_queue.push_back({c0, c1, c0});
        default: pixel_queue.push_back({pick_chan(), pick_chan(), pick_chan()});
      endcase
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pixel_queue.size() < 100);
    calm = 1'b1;
    wait (pixel_queue.size() == 0 && !s_axis_tvalid && hsl_expected.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && hsl_expected.size() == 0)
      $display("rgb_to_hsl_pixel_test passed");
    else
      $display("rgb_to_hsl_pixel_test failed");
    $finish;
  end

  initial begin
    #200000;
    $display("rgb_to_hsl_pixel_test failed");
    $finish;
  end

endmodule
`default_nettype wire
